// File: design/ewc_pkg.sv
// Shared types and constants for the windowed echo comb core.
// No dependencies; used by every module of the block.
package ewc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int WIN_W      = 16;
  localparam int BUFLEN_W   = 17;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int DEF_MAX_DELAY  = 4096;
  localparam int DEF_MAX_BUFFER = 65536;

  localparam logic [POS_W-1:0]  POS_MAX        = '1;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd16384;
  localparam logic [POS_W-1:0]  ROUND_BIAS     = 17'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_GAIN    = 3'd0,
    CFG_DELAY_SAMPLES = 3'd1,
    CFG_WINDOW_START  = 3'd2,
    CFG_WINDOW_END    = 3'd3,
    CFG_BUFFER_LENGTH = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   decay_gain;
    logic [DELAY_W-1:0]  delay_samples;
    logic [WIN_W-1:0]    window_start;
    logic [WIN_W-1:0]    window_end;
    logic [BUFLEN_W-1:0] buffer_length;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       first_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       echo_applied;
    logic                       config_error;
  } out_item_t;

endpackage

// File: design/windowed_echo_comb_core.sv
// Windowed feedforward echo on a Q1.15 sample stream: top level and pipeline control.
// Depends on ewc_pkg, ewc_cfg, ewc_delay and ewc_echo.
//
// One result per request, one request per cycle sustained while out_ready is high. The
// first stage writes the sample into the delay line and reads the echo tap (one memory
// port each), the second does the gain multiply, rounding and saturation into the output
// register. A result waiting at the output does not stop the next request being taken
// into the first stage while that stage is empty. Samples whose position lies in
// [window_start + delay_samples, window_end] get the echo added; with inconsistent
// window settings every sample passes unchanged with config_error set. The user must write
// configuration via cfg_we/cfg_addr/cfg_wdata only while no request is in flight (not enforced).
module windowed_echo_comb_core
  import ewc_pkg::*;
#(
  parameter int MAX_DELAY  = DEF_MAX_DELAY,
  parameter int MAX_BUFFER = DEF_MAX_BUFFER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t regs;
  logic      win_valid;

  logic accept;
  logic advance;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] win_lo;
  logic             apply;

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_cur_r;
  logic                       s1_apply_r;
  logic                       s1_err_r;
  logic                       s1_bypass_r;

  logic signed [SAMPLE_W-1:0] tap;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [SAMPLE_W-1:0] echo_sum;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  ewc_cfg #(
    .MAX_DELAY (MAX_DELAY),
    .MAX_BUFFER(MAX_BUFFER)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .regs     (regs),
    .win_valid(win_valid)
  );

  ewc_delay #(
    .MAX_DELAY(MAX_DELAY)
  ) u_delay (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .first  (in_data.first_of_buffer),
    .wr_data(in_data.sample_in),
    .delay  (regs.delay_samples),
    .rd_data(tap)
  );

  ewc_echo u_echo (
    .cur (s1_cur_r),
    .past(past),
    .gain(regs.decay_gain),
    .sum (echo_sum)
  );

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos     = in_data.first_of_buffer ? '0 : pos_r;
    pos_nxt = (pos == POS_MAX) ? POS_MAX : pos + POS_W'(1);
    win_lo  = POS_W'(regs.window_start) + POS_W'(regs.delay_samples);
    apply   = win_valid && (pos >= win_lo) && (pos <= POS_W'(regs.window_end));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // stage 1: delay line access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r    <= in_data.sample_in;
      s1_apply_r  <= apply;
      s1_err_r    <= !win_valid;
      s1_bypass_r <= (regs.delay_samples == '0);
    end
  end

  // zero delay echoes the current sample itself
  assign past = s1_bypass_r ? s1_cur_r : tap;

  always_comb begin
    out_data_nxt.sample_out   = s1_apply_r ? echo_sum : s1_cur_r;
    out_data_nxt.echo_applied = s1_apply_r;
    out_data_nxt.config_error = s1_err_r;
  end

  // stage 2: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/ewc_cfg.sv
// Configuration register file and window validity check.
// Depends on ewc_pkg.
module ewc_cfg
  import ewc_pkg::*;
#(
  parameter int MAX_DELAY  = DEF_MAX_DELAY,
  parameter int MAX_BUFFER = DEF_MAX_BUFFER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             regs,
  output logic                  win_valid
);

  localparam int LEN_BITS = $clog2(MAX_BUFFER + 1);
  localparam int CW       = ((LEN_BITS > BUFLEN_W) ? LEN_BITS : BUFLEN_W) + 1;
  localparam int DCW      = 18;

  cfg_regs_t regs_r, regs_nxt;

  logic [CW-1:0] len;
  logic [CW-1:0] start_plus_delay;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DECAY_GAIN:    regs_nxt.decay_gain    = cfg_wdata[GAIN_W-1:0];
        CFG_DELAY_SAMPLES: regs_nxt.delay_samples = cfg_wdata[DELAY_W-1:0];
        CFG_WINDOW_START:  regs_nxt.window_start  = cfg_wdata[WIN_W-1:0];
        CFG_WINDOW_END:    regs_nxt.window_end    = cfg_wdata[WIN_W-1:0];
        CFG_BUFFER_LENGTH: regs_nxt.buffer_length = cfg_wdata[BUFLEN_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.decay_gain    <= GAIN_RESET;
      regs_r.delay_samples <= '0;
      regs_r.window_start  <= '0;
      regs_r.window_end    <= '0;
      regs_r.buffer_length <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // buffer length is capped at the largest supported buffer, then the window is checked
  always_comb begin
    if (CW'(regs_r.buffer_length) > CW'(MAX_BUFFER)) begin
      len = CW'(MAX_BUFFER);
    end else begin
      len = CW'(regs_r.buffer_length);
    end
    start_plus_delay = CW'(regs_r.window_start) + CW'(regs_r.delay_samples);
    win_valid = !(regs_r.window_end < regs_r.window_start) &&
                (start_plus_delay < len) &&
                (CW'(regs_r.window_end) < len) &&
                (DCW'(regs_r.delay_samples) < DCW'(MAX_DELAY));
  end

  assign regs = regs_r;

endmodule

// File: design/ewc_delay.sv
// Delay line memory with its circular write pointer and echo tap address.
// Depends on ewc_pkg.
module ewc_delay
  import ewc_pkg::*;
#(
  parameter int MAX_DELAY = DEF_MAX_DELAY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic                       first,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [DELAY_W-1:0]         delay,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int RW = ((AW > DELAY_W) ? AW : DELAY_W) + 2;

  logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
  logic signed [SAMPLE_W-1:0] rd_r;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [RW-1:0] base_w;
  logic [RW-1:0] dly_w;

  // write slot follows the sample position modulo the line depth
  always_comb begin
    waddr = first ? '0 : wptr_r;
    if (waddr == AW'(MAX_DELAY - 1)) begin
      wptr_nxt = '0;
    end else begin
      wptr_nxt = waddr + AW'(1);
    end
    base_w = RW'(waddr);
    dly_w  = RW'(delay);
    if (base_w >= dly_w) begin
      raddr = AW'(base_w - dly_w);
    end else begin
      raddr = AW'(base_w + RW'(MAX_DELAY) - dly_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
    end else if (wr_en) begin
      wptr_r <= wptr_nxt;
    end
  end

  // read sees the old contents; zero delay is bypassed by the caller
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr_data;
      rd_r       <= mem[raddr];
    end
  end

  assign rd_data = rd_r;

endmodule

// File: design/ewc_echo.sv
// Echo arithmetic: delayed sample times gain, rounded, added and saturated.
// Depends on ewc_pkg.
module ewc_echo
  import ewc_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] cur,
  input  logic signed [SAMPLE_W-1:0] past,
  input  logic [GAIN_W-1:0]          gain,
  output logic signed [SAMPLE_W-1:0] sum
);

  logic signed [32:0] prod;
  logic signed [33:0] rnd;
  logic signed [18:0] q;
  logic signed [19:0] s;

  always_comb begin
    prod = past * $signed({1'b0, gain});
    // Q2.30 to Q1.15, round half up
    rnd  = 34'(prod) + $signed({17'd0, ROUND_BIAS});
    q    = rnd[33:15];
    s    = 20'(cur) + 20'(q);
    if (s > 20'sd32767) begin
      sum = 16'sh7fff;
    end else if (s < -20'sd32768) begin
      sum = 16'sh8000;
    end else begin
      sum = s[SAMPLE_W-1:0];
    end
  end

endmodule

// File: tb/windowed_echo_comb_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_echo_comb_core: directed and random sample streams,
// a local model of the windowed echo and an in-order scoreboard. Depends on ewc_pkg and the RTL.
module windowed_echo_comb_core_test;
  import ewc_pkg::*;

  localparam int DLY_DEPTH   = 4096;
  localparam int LEN_CAP     = 65536;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 50;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  windowed_echo_comb_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the block's state and registers
  logic [SAMPLE_W-1:0] echo_mem [DLY_DEPTH];
  logic [POS_W-1:0]    next_pos = '0;
  logic [GAIN_W-1:0]   m_gain   = GAIN_RESET;
  logic [DELAY_W-1:0]  m_delay  = '0;
  logic [WIN_W-1:0]    m_start  = '0;
  logic [WIN_W-1:0]    m_end    = '0;
  logic [BUFLEN_W-1:0] m_len    = '0;

  out_item_t expected_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int n_fail         = 0;
  int n_sent         = 0;
  int n_recv         = 0;
  int n_echo         = 0;
  int n_cfg_err      = 0;
  int n_settings     = 0;
  int quiet          = 0;

  function automatic bit window_ok();
    int len;
    len = (int'(m_len) > LEN_CAP) ? LEN_CAP : int'(m_len);
    if (int'(m_end) < int'(m_start)) return 1'b0;
    if (int'(m_start) + int'(m_delay) >= len) return 1'b0;
    if (int'(m_end) >= len) return 1'b0;
    if (int'(m_delay) >= DLY_DEPTH) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_echo(in_item_t it);
    out_item_t   r;
    int unsigned pos;
    int          cur;
    int          past;
    longint      prod;
    longint      total;
    bit          ok;
    ok   = window_ok();
    pos  = it.first_of_buffer ? 0 : int'(next_pos);
    cur  = it.sample_in;
    echo_mem[pos % DLY_DEPTH] = it.sample_in;
    r.sample_out   = it.sample_in;
    r.echo_applied = 1'b0;
    r.config_error = !ok;
    if (ok && pos >= int'(m_start) + int'(m_delay) && pos <= int'(m_end)) begin
      past  = $signed(echo_mem[(pos - m_delay) % DLY_DEPTH]);
      prod  = longint'(past) * longint'(int'(m_gain));
      // round half up to Q1.15, then clip
      total = longint'(cur) + ((prod + 16384) >>> 15);
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      r.sample_out   = total[SAMPLE_W-1:0];
      r.echo_applied = 1'b1;
    end
    next_pos = (pos >= POS_MAX) ? POS_MAX : POS_W'(pos + 1);
    return r;
  endfunction

  function automatic void flag_field(string field, int want, int got);
    n_fail++;
    if (n_fail <= REPORT_MAX)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  // scoreboard: predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      want = predict_echo(in_data);
      expected_q.push_back(want);
      n_sent++;
      if (want.echo_applied) n_echo++;
      if (want.config_error) n_cfg_err++;
    end
    if (rst_n && out_valid && out_ready) begin
      n_recv++;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_MAX) $error("result arrived with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (out_data.sample_out !== want.sample_out)
          flag_field("sample_out", $signed(want.sample_out), $signed(out_data.sample_out));
        if (out_data.echo_applied !== want.echo_applied)
          flag_field("echo_applied", want.echo_applied, out_data.echo_applied);
        if (out_data.config_error !== want.config_error)
          flag_field("config_error", want.config_error, out_data.config_error);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_in: smp, first_of_buffer: first};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int gain, input int dly, input int wstart, input int wend,
                            input int blen);
    put_reg(CFG_DECAY_GAIN, gain);
    put_reg(CFG_DELAY_SAMPLES, dly);
    put_reg(CFG_WINDOW_START, wstart);
    put_reg(CFG_WINDOW_END, wend);
    put_reg(CFG_BUFFER_LENGTH, blen);
    cfg_we <= 1'b0;
    m_gain  = GAIN_W'(gain);
    m_delay = DELAY_W'(dly);
    m_start = WIN_W'(wstart);
    m_end   = WIN_W'(wend);
    m_len   = BUFLEN_W'(blen);
    n_settings++;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // reset registers describe an empty buffer, so every sample is flagged
  task automatic test_reset_defaults();
    send_sample(16'sd1234, 1'b1);
    send_sample(-16'sd77, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_echo_extremes();
    set_config(65535, 2, 0, 11, 16);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd16384, 1'b0);
    send_sample(-16'sd16384, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(-16'sd1, 1'b1);
    wait_drained();
  endtask

  // zero delay taps the current sample; window ends on the last position of the buffer
  task automatic test_unity_gain_no_delay();
    set_config(32768, 0, 0, 3, 4);
    send_sample(16'sd20000, 1'b1);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'sd555, 1'b0);
    wait_drained();
  endtask

  task automatic test_invalid_windows();
    set_config(20000, 0, 65535, 5, 64);      // end before start
    send_sample(16'sd300, 1'b1);
    send_sample(-16'sd300, 1'b0);
    wait_drained();
    set_config(20000, 4, 60, 63, 64);        // start plus delay reaches the length
    send_sample(16'sd9, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    wait_drained();
    set_config(20000, 0, 0, 65535, 65535);   // end at the length
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd42, 1'b0);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config($urandom_range(65535), 3, 0, 40, 64);
    hold_left = 80;
    for (int i = 0; i < 40; i++)
      send_sample(pick_sample(), i == 0);
    wait_drained();
  endtask

  // buffer length above the largest supported buffer is capped before the window checks
  task automatic test_length_cap();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config($urandom_range(65535), 5, 3, 25, 131071);
    send_sample(pick_sample(), 1'b1);
    for (int i = 0; i < 28; i++)
      send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_streams();
    int gain;
    int dly;
    int wstart;
    int wend;
    int len;
    int left;
    int run;
    for (int round = 0; round < 8; round++) begin
      case (round % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case ($urandom_range(5))
        0:       gain = 0;
        1:       gain = 65535;
        2:       gain = 32768;
        default: gain = $urandom_range(65535);
      endcase
      len    = $urandom_range(2, 150);
      wstart = $urandom_range(0, len / 3);
      if ($urandom_range(3) == 0)
        dly = $urandom_range(0, len - 1 - wstart);
      else
        dly = $urandom_range(0, (len - 1 - wstart < 16) ? len - 1 - wstart : 16);
      wend = $urandom_range(wstart, len - 1);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: begin wstart = $urandom_range(1, 65535); wend = $urandom_range(0, wstart - 1); end
          1: dly = len - wstart;
          default: wend = $urandom_range(len, 65535);
        endcase
      end
      set_config(gain, dly, wstart, wend, len);
      left = 220;
      while (left > 0) begin
        // mostly whole buffers, now and then a cut-short one
        run = ($urandom_range(5) == 0) ? $urandom_range(1, len) : len;
        if (run > left) run = left;
        for (int i = 0; i < run; i++)
          send_sample(pick_sample(), i == 0 || $urandom_range(49) == 0);
        left -= run;
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_echo_extremes();
    test_unity_gain_no_delay();
    test_invalid_windows();
    test_back_pressure();
    test_length_cap();
    test_random_streams();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d samples over %0d register settings, %0d results checked.",
             n_sent, n_settings, n_recv);
    $display("%0d samples took the echo, %0d saw an invalid window.", n_echo, n_cfg_err);
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: windowed_echo_comb_core.f
design/ewc_pkg.sv
design/ewc_cfg.sv
design/ewc_delay.sv
design/ewc_echo.sv
design/windowed_echo_comb_core.sv
tb/windowed_echo_comb_core_test.sv
